[src/calendar_date_arithmetic_core_assert.svh]
// ----------------------------------------------------------------------------
// Calendar date arithmetic core: assertion macros
// Implication checks on the core clock, disabled while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef CALENDAR_DATE_ARITHMETIC_CORE_ASSERT_SVH
`define CALENDAR_DATE_ARITHMETIC_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define CDA_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define CDA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define CDA_ASSERT_IMPLY(label, ante, cons, msg)
`define CDA_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

[src/cda_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Calendar date arithmetic package
// Field widths, operation codes, transaction structs and the month length
// function shared by the engine and the top level.
// ----------------------------------------------------------------------------
package cda_pkg;

  // Field widths
  localparam int DAY_W     = 5;
  localparam int MONTH_W   = 4;
  localparam int YEAR_W    = 14;
  localparam int OFFSET_W  = 16;
  localparam int EPOCH_W   = 22;
  localparam int IN_DATA_W = 64;
  localparam int IN_USER_W = 2;
  localparam int OUT_DATA_W = 32;

  // Shared adder and epoch divider widths
  localparam int ALU_W     = 18;
  localparam int DVD_W     = EPOCH_W + 1;
  localparam int REM_W     = 11;
  localparam int QUO_W     = 12;

  // Reciprocal of the four-year cycle length, scaled by 2^RECIP_SHIFT.
  // The quotient it gives is exact for every dividend below 2^23.
  localparam int               RECIP_SHIFT      = 33;
  localparam logic [DVD_W-1:0] FOUR_YEARS_RECIP = 23'd5879490;

  // Calendar constants
  localparam logic [YEAR_W-1:0]  YEAR_MIN         = 14'd1;
  localparam logic [YEAR_W-1:0]  YEAR_MAX         = 14'd9999;
  localparam logic [YEAR_W-1:0]  RESET_YEAR       = 14'd1970;
  localparam logic [YEAR_W-1:0]  EPOCH_CYCLE_YEAR = 14'd1968;
  localparam logic [MONTH_W-1:0] MONTH_JAN        = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB        = 4'd2;
  localparam logic [MONTH_W-1:0] MONTHS           = 4'd12;
  localparam logic [DAY_W-1:0]   FIRST_DAY        = 5'd1;
  localparam logic [REM_W-1:0]   FOUR_YEARS       = 11'd1461;
  localparam logic [9:0]         EPOCH_SHIFT      = 10'd731;
  localparam logic [8:0]         LEAP_YEAR_DAYS   = 9'd366;
  localparam logic [8:0]         YEAR_DAYS        = 9'd365;

  localparam logic [DAY_W-1:0] MONTH_DAYS [12] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  // Operation selector
  typedef enum logic [1:0] {
    MODE_LOAD    = 2'd0,
    MODE_ADD     = 2'd1,
    MODE_COMPARE = 2'd2,
    MODE_EPOCH   = 2'd3
  } mode_t;

  // Compare outcome
  typedef enum logic [1:0] {
    ORDER_EQUAL   = 2'd0,
    ORDER_LATER   = 2'd1,
    ORDER_EARLIER = 2'd2
  } order_t;

  // One input transaction
  typedef struct packed {
    mode_t                      mode;
    logic [DAY_W-1:0]           day;
    logic [MONTH_W-1:0]         month;
    logic [YEAR_W-1:0]          year;
    logic signed [OFFSET_W-1:0] day_offset;
    logic [EPOCH_W-1:0]         epoch_days;
  } in_t;

  // One result transaction
  typedef struct packed {
    logic [DAY_W-1:0]   day;
    logic [MONTH_W-1:0] month;
    logic [YEAR_W-1:0]  year;
    logic               valid;
    order_t             order;
    logic               oor;
  } res_t;

  // Shared adder control and result
  typedef struct packed {
    logic signed [ALU_W-1:0] a;
    logic signed [ALU_W-1:0] b;
    logic                    sub;
  } alu_ctl_t;

  typedef struct packed {
    logic signed [ALU_W-1:0] sum;
    logic                    neg;
    logic                    pos;
  } alu_res_t;

  // Days in a month; zero for a month outside 1 to 12. Every fourth year leaps.
  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] month,
                                                 input logic [YEAR_W-1:0]  year);
    logic [DAY_W-1:0] len;
    len = '0;
    if (month >= MONTH_JAN && month <= MONTHS) begin
      len = MONTH_DAYS[month - MONTH_JAN];
      if (month == MONTH_FEB && year[1:0] == 2'b00) begin
        len = len + 5'd1;
      end
    end
    return len;
  endfunction

endpackage

[src/calendar_date_arithmetic_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Calendar date arithmetic core
// Keeps one calendar date and loads, shifts, compares or sets it from an
// epoch day count, one operation per input transaction.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream takes one operation per transaction; tuser selects load,
//   add days, compare or epoch conversion. The master stream returns one
//   result transaction per input: the stored date after the operation plus
//   the valid, order and out-of-range flags.
//   Load and compare finish straight from the input; add walks the date
//   month by month from the shifted day; epoch conversion runs the
//   reciprocal division and then the year and month walks.
//   Day and month arithmetic runs through one shared adder, and only one
//   operation is in the engine at a time; a new transaction is taken only
//   after the previous result has moved to the output register.
//   The output register holds a result while the receiver stalls; the engine
//   finishes the next operation and then waits for that register to free up.
//   Reset stores 1 January 1970 and empties the output register.
// ----------------------------------------------------------------------------
`include "calendar_date_arithmetic_core_assert.svh"

module calendar_date_arithmetic_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // in_day[4:0], in_month[8:5], in_year[22:9], day_offset[38:23],
  // epoch_days[60:39], zero fill above
  input  logic [cda_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // mode[1:0]
  input  logic [cda_pkg::IN_USER_W-1:0]  s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // out_day[4:0], out_month[8:5], out_year[22:9], valid_res[23], order[25:24],
  // out_of_range[26], zero fill above
  output logic [cda_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
  import cda_pkg::*;

  in_t  in_item;
  res_t eng_res;
  res_t out_res;
  logic eng_idle;
  logic eng_done;
  logic out_valid;
  logic res_ready;

  // Unpack the input transaction.
  assign in_item.mode       = mode_t'(s_axis_tuser);
  assign in_item.day        = s_axis_tdata[4:0];
  assign in_item.month      = s_axis_tdata[8:5];
  assign in_item.year       = s_axis_tdata[22:9];
  assign in_item.day_offset = $signed(s_axis_tdata[38:23]);
  assign in_item.epoch_days = s_axis_tdata[60:39];

  assign s_axis_tready = eng_idle;

  cda_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .start     (s_axis_tvalid),
    .item      (in_item),
    .idle      (eng_idle),
    .done      (eng_done),
    .res_ready (res_ready),
    .res       (eng_res)
  );

  // Output register: loads when empty or being drained.
  assign res_ready = !out_valid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (eng_done && res_ready) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (eng_done && res_ready) begin
      out_res <= eng_res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {5'b0, out_res.oor, out_res.order, out_res.valid,
                          out_res.year, out_res.month, out_res.day};

  // The stored date reported with every result is a legal date.
  `CDA_ASSERT_IMPLY(a_result_date_legal, m_axis_tvalid,
    (out_res.month >= MONTH_JAN && out_res.month <= MONTHS && out_res.day != '0 &&
     out_res.day <= month_len(out_res.month, out_res.year) &&
     out_res.year >= YEAR_MIN && out_res.year <= YEAR_MAX),
    "result date is not a legal calendar date")

  // An accepted transaction leaves the engine busy in the cycle after.
  `CDA_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready,
    !s_axis_tready, "engine ready again right after accepting a transaction")

  // Only defined order codes, and a compare never flags out of range.
  `CDA_ASSERT_IMPLY(a_order_code, m_axis_tvalid,
    (out_res.order == ORDER_EQUAL ||
     ((out_res.order == ORDER_LATER || out_res.order == ORDER_EARLIER) && !out_res.oor)),
    "bad order code or order reported with out of range")

endmodule

[src/cda_alu.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Calendar date shared adder
// Signed add or subtract with sign and strictly-positive flags, used by the
// engine for day walking, the epoch remainder and the year and month walk.
// ----------------------------------------------------------------------------
module cda_alu (
  input  cda_pkg::alu_ctl_t ctl,
  output cda_pkg::alu_res_t res
);
  import cda_pkg::*;

  logic signed [ALU_W-1:0] sum;

  // One adder serves both directions.
  assign sum = ctl.sub ? (ctl.a - ctl.b) : (ctl.a + ctl.b);

  assign res.sum = sum;
  assign res.neg = sum[ALU_W-1];
  assign res.pos = !sum[ALU_W-1] && (sum != '0);

endmodule

[src/cda_engine.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Calendar date engine
// Holds the current date and runs one operation at a time under a small
// sequencer that steps the shared adder: month walk for add, reciprocal
// division plus year and month walk for epoch conversion.
// ----------------------------------------------------------------------------
module cda_engine (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  cda_pkg::in_t  item,
  output logic          idle,
  output logic          done,
  input  logic          res_ready,
  output cda_pkg::res_t res
);
  import cda_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD,
    ST_EP_DIV,
    ST_EP_REM,
    ST_EP_YEAR,
    ST_EP_MONTH,
    ST_DONE
  } state_t;

  state_t                  state;
  logic [DAY_W-1:0]        cur_day;
  logic [MONTH_W-1:0]      cur_month;
  logic [YEAR_W-1:0]       cur_year;
  logic signed [ALU_W-1:0] acc;
  logic [MONTH_W-1:0]      w_mon;
  logic [YEAR_W-1:0]       w_yr;
  logic [DVD_W-1:0]        dvd;
  logic [QUO_W-1:0]        quo;
  logic                    first_yr;
  logic                    flag_valid;
  order_t                  flag_order;
  logic                    flag_oor;

  alu_ctl_t                alu_ctl;
  alu_res_t                alu_res;

  logic [DAY_W-1:0]        in_len;
  logic                    in_ok;
  logic                    in_year_oor;
  order_t                  ord;
  logic [DAY_W-1:0]        w_len;
  logic [MONTH_W-1:0]      prev_mon;
  logic [YEAR_W-1:0]       prev_yr;
  logic [DAY_W-1:0]        prev_len;
  logic                    wrap_low;
  logic                    acc_low;
  logic [2*DVD_W-1:0]      recip_prod;
  logic [QUO_W+REM_W-1:0]  quo_prod;
  logic [REM_W-1:0]        rem_next;
  logic [YEAR_W-1:0]       yr_base;

  cda_alu u_alu (
    .ctl (alu_ctl),
    .res (alu_res)
  );

  // Legality of the given date for load and compare.
  assign in_len      = month_len(item.month, item.year);
  assign in_ok       = (in_len != '0) && (item.day != '0) && (item.day <= in_len);
  assign in_year_oor = (item.year < YEAR_MIN) || (item.year > YEAR_MAX);

  // Order of the given date against the stored one, field by field.
  always_comb begin
    ord = ORDER_EQUAL;
    if (item.year != cur_year) begin
      ord = (item.year > cur_year) ? ORDER_LATER : ORDER_EARLIER;
    end else if (item.month != cur_month) begin
      ord = (item.month > cur_month) ? ORDER_LATER : ORDER_EARLIER;
    end else if (item.day != cur_day) begin
      ord = (item.day > cur_day) ? ORDER_LATER : ORDER_EARLIER;
    end
  end

  // Month walk helpers.
  assign w_len    = month_len(w_mon, w_yr);
  assign prev_mon = (w_mon == MONTH_JAN) ? MONTHS : (w_mon - 4'd1);
  assign prev_yr  = (w_mon == MONTH_JAN) ? (w_yr - 14'd1) : w_yr;
  assign prev_len = month_len(prev_mon, prev_yr);
  assign wrap_low = (w_mon == MONTH_JAN) && (w_yr == YEAR_MIN);
  assign acc_low  = acc[ALU_W-1] || (acc == '0);

  // Division by the four-year cycle: the quotient comes from a reciprocal
  // multiplication, the remainder from the low bits of dividend minus
  // quotient times cycle length, which always fit in REM_W bits.
  assign recip_prod = {{DVD_W{1'b0}}, dvd} * {{DVD_W{1'b0}}, FOUR_YEARS_RECIP};
  assign quo_prod   = {{REM_W{1'b0}}, quo} * {{QUO_W{1'b0}}, FOUR_YEARS};
  assign rem_next   = alu_res.sum[REM_W-1:0];
  assign yr_base    = EPOCH_CYCLE_YEAR + {quo, 2'b00};

  // Operand selection for the shared adder.
  always_comb begin
    alu_ctl.a   = acc;
    alu_ctl.b   = '0;
    alu_ctl.sub = 1'b0;
    case (state)
      ST_IDLE: begin
        alu_ctl.a = ALU_W'({1'b0, cur_day});
        alu_ctl.b = ALU_W'(item.day_offset);
      end
      ST_ADD: begin
        if (acc_low) begin
          alu_ctl.b = ALU_W'({1'b0, prev_len});
        end else begin
          alu_ctl.b   = ALU_W'({1'b0, w_len});
          alu_ctl.sub = 1'b1;
        end
      end
      ST_EP_REM: begin
        alu_ctl.a   = ALU_W'({1'b0, dvd[REM_W-1:0]});
        alu_ctl.b   = ALU_W'({1'b0, quo_prod[REM_W-1:0]});
        alu_ctl.sub = 1'b1;
      end
      ST_EP_YEAR: begin
        alu_ctl.b   = first_yr ? ALU_W'({1'b0, LEAP_YEAR_DAYS}) : ALU_W'({1'b0, YEAR_DAYS});
        alu_ctl.sub = 1'b1;
      end
      ST_EP_MONTH: begin
        alu_ctl.b   = ALU_W'({1'b0, w_len});
        alu_ctl.sub = 1'b1;
      end
      default: begin
        alu_ctl.b = '0;
      end
    endcase
  end

  // Sequencer, stored date and result flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cur_day   <= FIRST_DAY;
      cur_month <= MONTH_JAN;
      cur_year  <= RESET_YEAR;
    end else begin
      case (state)
        ST_IDLE: begin
          if (start) begin
            case (item.mode)
              MODE_LOAD: begin
                flag_valid <= in_ok;
                flag_order <= ORDER_EQUAL;
                flag_oor   <= in_year_oor;
                if (in_ok && !in_year_oor) begin
                  cur_day   <= item.day;
                  cur_month <= item.month;
                  cur_year  <= item.year;
                end
                state <= ST_DONE;
              end
              MODE_COMPARE: begin
                flag_valid <= in_ok;
                flag_order <= ord;
                flag_oor   <= 1'b0;
                state      <= ST_DONE;
              end
              MODE_ADD: begin
                flag_valid <= 1'b0;
                flag_order <= ORDER_EQUAL;
                flag_oor   <= 1'b0;
                acc        <= alu_res.sum;
                w_mon      <= cur_month;
                w_yr       <= cur_year;
                state      <= ST_ADD;
              end
              MODE_EPOCH: begin
                flag_valid <= 1'b0;
                flag_order <= ORDER_EQUAL;
                flag_oor   <= 1'b0;
                dvd        <= DVD_W'(item.epoch_days) + DVD_W'(EPOCH_SHIFT);
                state      <= ST_EP_DIV;
              end
              default: begin
                flag_valid <= 1'b0;
                flag_order <= ORDER_EQUAL;
                flag_oor   <= 1'b0;
                state      <= ST_DONE;
              end
            endcase
          end
        end

        ST_ADD: begin
          if (acc_low) begin
            // Borrow a whole month from the one before.
            if (wrap_low) begin
              flag_oor <= 1'b1;
              state    <= ST_DONE;
            end else begin
              acc   <= alu_res.sum;
              w_mon <= prev_mon;
              w_yr  <= prev_yr;
            end
          end else if (alu_res.pos) begin
            // Day runs past this month: move to the next one.
            acc <= alu_res.sum;
            if (w_mon == MONTHS) begin
              w_mon <= MONTH_JAN;
              w_yr  <= w_yr + 14'd1;
              if (w_yr == YEAR_MAX) begin
                flag_oor <= 1'b1;
                state    <= ST_DONE;
              end
            end else begin
              w_mon <= w_mon + 4'd1;
            end
          end else begin
            cur_day   <= acc[DAY_W-1:0];
            cur_month <= w_mon;
            cur_year  <= w_yr;
            state     <= ST_DONE;
          end
        end

        ST_EP_DIV: begin
          // Number of whole four-year cycles since 1968.
          quo   <= recip_prod[RECIP_SHIFT +: QUO_W];
          state <= ST_EP_REM;
        end

        ST_EP_REM: begin
          // Day within the cycle and the first year of the cycle.
          acc      <= ALU_W'({1'b0, rem_next});
          w_yr     <= yr_base;
          first_yr <= 1'b1;
          state    <= ST_EP_YEAR;
        end

        ST_EP_YEAR: begin
          // Leap year first in the four-year cycle, then common years.
          if (!alu_res.neg) begin
            acc      <= alu_res.sum;
            w_yr     <= w_yr + 14'd1;
            first_yr <= 1'b0;
          end else begin
            w_mon <= MONTH_JAN;
            state <= ST_EP_MONTH;
          end
        end

        ST_EP_MONTH: begin
          if (w_mon != MONTHS && !alu_res.neg) begin
            acc   <= alu_res.sum;
            w_mon <= w_mon + 4'd1;
          end else begin
            if (w_yr > YEAR_MAX) begin
              flag_oor <= 1'b1;
            end else begin
              flag_valid <= 1'b1;
              cur_day    <= acc[DAY_W-1:0] + FIRST_DAY;
              cur_month  <= w_mon;
              cur_year   <= w_yr;
            end
            state <= ST_DONE;
          end
        end

        ST_DONE: begin
          if (res_ready) begin
            state <= ST_IDLE;
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign idle = (state == ST_IDLE);
  assign done = (state == ST_DONE);

  assign res.day   = cur_day;
  assign res.month = cur_month;
  assign res.year  = cur_year;
  assign res.valid = flag_valid;
  assign res.order = flag_order;
  assign res.oor   = flag_oor;

endmodule

[tb/calendar_date_arithmetic_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Calendar date arithmetic core testbench
// Drives load, add, compare and epoch transactions through the slave stream
// and checks every result against a date predictor kept in step with the
// core. A short scripted run covers the calendar corners and range errors,
// then random traffic with bursty input and a stalling receiver follows.
// ----------------------------------------------------------------------------
module calendar_date_arithmetic_core_tb;
  import cda_pkg::*;

  localparam int RANDOM_OPS   = 540;
  localparam int DRAIN_CYCLES = 1200;
  localparam int HOLD_CYCLES  = 400;
  localparam int HOLD_AFTER   = 40;

  // One scripted operation; the expected result is used only when typed is set.
  typedef struct packed {
    in_t  op;
    logic typed;
    res_t res;
  } script_row_t;

  localparam res_t NONE = '{5'd0, 4'd0, 14'd0, 1'b0, ORDER_EQUAL, 1'b0};

  localparam int SCRIPT_LEN = 25;
  localparam script_row_t DATE_SCRIPT [SCRIPT_LEN] = '{
    // Reset date compared with itself, then the epoch origin.
    '{'{MODE_COMPARE, 5'd1, 4'd1, 14'd1970, 16'h0000, 22'd0}, 1'b1,
      '{5'd1, 4'd1, 14'd1970, 1'b1, ORDER_EQUAL, 1'b0}},
    '{'{MODE_EPOCH, 5'd0, 4'd0, 14'd0, 16'h0000, 22'd0}, 1'b1,
      '{5'd1, 4'd1, 14'd1970, 1'b1, ORDER_EQUAL, 1'b0}},
    // Leap day, then illegal loads that leave it in place.
    '{'{MODE_LOAD, 5'd29, 4'd2, 14'd2000, 16'h0000, 22'd0}, 1'b1,
      '{5'd29, 4'd2, 14'd2000, 1'b1, ORDER_EQUAL, 1'b0}},
    '{'{MODE_LOAD, 5'd29, 4'd2, 14'd2001, 16'h0000, 22'd0}, 1'b1,
      '{5'd29, 4'd2, 14'd2000, 1'b0, ORDER_EQUAL, 1'b0}},
    '{'{MODE_LOAD, 5'd0, 4'd5, 14'd2010, 16'h0000, 22'd0}, 1'b1,
      '{5'd29, 4'd2, 14'd2000, 1'b0, ORDER_EQUAL, 1'b0}},
    '{'{MODE_LOAD, 5'd1, 4'd13, 14'd2010, 16'h0000, 22'd0}, 1'b1,
      '{5'd29, 4'd2, 14'd2000, 1'b0, ORDER_EQUAL, 1'b0}},
    '{'{MODE_LOAD, 5'd31, 4'd0, 14'd2010, 16'h0000, 22'd0}, 1'b1,
      '{5'd29, 4'd2, 14'd2000, 1'b0, ORDER_EQUAL, 1'b0}},
    // Legal day and month in year zero, then every field at its top.
    '{'{MODE_LOAD, 5'd15, 4'd6, 14'd0, 16'h0000, 22'd0}, 1'b1,
      '{5'd29, 4'd2, 14'd2000, 1'b1, ORDER_EQUAL, 1'b1}},
    '{'{MODE_LOAD, 5'd31, 4'd15, 14'd16383, 16'h0000, 22'd0}, 1'b1,
      '{5'd29, 4'd2, 14'd2000, 1'b0, ORDER_EQUAL, 1'b1}},
    // Small steps across the end of February.
    '{'{MODE_ADD, 5'd0, 4'd0, 14'd0, 16'h0000, 22'd0}, 1'b0, NONE},
    '{'{MODE_ADD, 5'd0, 4'd0, 14'd0, 16'h0001, 22'd0}, 1'b0, NONE},
    '{'{MODE_ADD, 5'd0, 4'd0, 14'd0, 16'hFFFF, 22'd0}, 1'b0, NONE},
    // Ordering, including dates that are not legal.
    '{'{MODE_COMPARE, 5'd1, 4'd3, 14'd2000, 16'h0000, 22'd0}, 1'b1,
      '{5'd29, 4'd2, 14'd2000, 1'b1, ORDER_LATER, 1'b0}},
    '{'{MODE_COMPARE, 5'd28, 4'd2, 14'd2000, 16'h0000, 22'd0}, 1'b1,
      '{5'd29, 4'd2, 14'd2000, 1'b1, ORDER_EARLIER, 1'b0}},
    '{'{MODE_COMPARE, 5'd31, 4'd15, 14'd16383, 16'h0000, 22'd0}, 1'b1,
      '{5'd29, 4'd2, 14'd2000, 1'b0, ORDER_LATER, 1'b0}},
    // Walks off both ends of the year range, and the widest offsets.
    '{'{MODE_LOAD, 5'd31, 4'd12, 14'd9999, 16'h0000, 22'd0}, 1'b1,
      '{5'd31, 4'd12, 14'd9999, 1'b1, ORDER_EQUAL, 1'b0}},
    '{'{MODE_ADD, 5'd0, 4'd0, 14'd0, 16'h0001, 22'd0}, 1'b1,
      '{5'd31, 4'd12, 14'd9999, 1'b0, ORDER_EQUAL, 1'b1}},
    '{'{MODE_ADD, 5'd0, 4'd0, 14'd0, 16'h8000, 22'd0}, 1'b0, NONE},
    '{'{MODE_LOAD, 5'd1, 4'd1, 14'd1, 16'h0000, 22'd0}, 1'b1,
      '{5'd1, 4'd1, 14'd1, 1'b1, ORDER_EQUAL, 1'b0}},
    '{'{MODE_ADD, 5'd0, 4'd0, 14'd0, 16'hFFFF, 22'd0}, 1'b1,
      '{5'd1, 4'd1, 14'd1, 1'b0, ORDER_EQUAL, 1'b1}},
    '{'{MODE_ADD, 5'd0, 4'd0, 14'd0, 16'h7FFF, 22'd0}, 1'b0, NONE},
    // Last epoch day in range, the first one past it, and all ones.
    '{'{MODE_EPOCH, 5'd0, 4'd0, 14'd0, 16'h0000, 22'd2932956}, 1'b1,
      '{5'd31, 4'd12, 14'd9999, 1'b1, ORDER_EQUAL, 1'b0}},
    '{'{MODE_EPOCH, 5'd0, 4'd0, 14'd0, 16'h0000, 22'd2932957}, 1'b1,
      '{5'd31, 4'd12, 14'd9999, 1'b0, ORDER_EQUAL, 1'b1}},
    '{'{MODE_EPOCH, 5'd0, 4'd0, 14'd0, 16'h0000, 22'h3FFFFF}, 1'b1,
      '{5'd31, 4'd12, 14'd9999, 1'b0, ORDER_EQUAL, 1'b1}},
    // Leap day of the first leap year after the epoch.
    '{'{MODE_EPOCH, 5'd0, 4'd0, 14'd0, 16'h0000, 22'd789}, 1'b0, NONE}
  };

  logic                  clk;
  logic                  rst;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic [IN_USER_W-1:0]  s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  // Predicted stored date
  logic [DAY_W-1:0]   cal_day;
  logic [MONTH_W-1:0] cal_month;
  logic [YEAR_W-1:0]  cal_year;

  res_t expected_dates [$];
  int   mismatch_count = 0;
  int   results_seen = 0;
  int   burst_left = 0;

  calendar_date_arithmetic_core dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // 100 MHz clock.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Month length with a leap February in every fourth year; zero for a bad month.
  function automatic int days_in(input int mon, input int yr);
    int n;
    case (mon)
      1, 3, 5, 7, 8, 10, 12: n = 31;
      4, 6, 9, 11:           n = 30;
      2:                     n = (yr % 4 == 0) ? 29 : 28;
      default:               n = 0;
    endcase
    return n;
  endfunction

  // Applies one operation to the predicted date and returns the result it gives.
  function automatic res_t advance_calendar(input in_t op);
    res_t r;
    int   len;
    int   d;
    int   m;
    int   y;
    int   t;
    r = NONE;
    case (op.mode)
      MODE_LOAD, MODE_COMPARE: begin
        len = days_in(int'(op.month), int'(op.year));
        r.valid = (op.day != 5'd0 && int'(op.day) <= len);
        if (op.mode == MODE_LOAD) begin
          r.oor = (op.year < YEAR_MIN || op.year > YEAR_MAX);
          if (r.valid && !r.oor) begin
            cal_day   = op.day;
            cal_month = op.month;
            cal_year  = op.year;
          end
        end else if (op.year != cal_year) begin
          r.order = (op.year > cal_year) ? ORDER_LATER : ORDER_EARLIER;
        end else if (op.month != cal_month) begin
          r.order = (op.month > cal_month) ? ORDER_LATER : ORDER_EARLIER;
        end else if (op.day != cal_day) begin
          r.order = (op.day > cal_day) ? ORDER_LATER : ORDER_EARLIER;
        end
      end
      MODE_ADD: begin
        d = int'(cal_day) + int'(op.day_offset);
        m = int'(cal_month);
        y = int'(cal_year);
        // Forward, one month at a time.
        while (!r.oor && d > days_in(m, y)) begin
          d = d - days_in(m, y);
          m = m + 1;
          if (m > 12) begin
            m = 1;
            y = y + 1;
            if (y > int'(YEAR_MAX)) r.oor = 1'b1;
          end
        end
        // Backward, borrowing the length of the previous month.
        while (!r.oor && d < 1) begin
          m = m - 1;
          if (m < 1) begin
            m = 12;
            y = y - 1;
          end
          if (y < int'(YEAR_MIN)) r.oor = 1'b1;
          else d = d + days_in(m, y);
        end
        if (!r.oor) begin
          cal_day   = DAY_W'(d);
          cal_month = MONTH_W'(m);
          cal_year  = YEAR_W'(y);
        end
      end
      default: begin
        // Count from 1 January 1968, the start of a four-year cycle.
        t = int'(op.epoch_days) + int'(EPOCH_SHIFT);
        y = int'(EPOCH_CYCLE_YEAR) + 4 * (t / int'(FOUR_YEARS));
        d = t % int'(FOUR_YEARS);
        if (d >= int'(LEAP_YEAR_DAYS)) begin
          d = d - int'(LEAP_YEAR_DAYS);
          y = y + 1 + d / int'(YEAR_DAYS);
          d = d % int'(YEAR_DAYS);
        end
        m = 1;
        while (m < 12 && d >= days_in(m, y)) begin
          d = d - days_in(m, y);
          m = m + 1;
        end
        if (y > int'(YEAR_MAX)) begin
          r.oor = 1'b1;
        end else begin
          r.valid   = 1'b1;
          cal_day   = DAY_W'(d + 1);
          cal_month = MONTH_W'(m);
          cal_year  = YEAR_W'(y);
        end
      end
    endcase
    r.day   = cal_day;
    r.month = cal_month;
    r.year  = cal_year;
    return r;
  endfunction

  // Year for a legal date, often close to either end of the range.
  function automatic logic [YEAR_W-1:0] pick_year();
    if ($urandom_range(0, 7) != 0) return YEAR_W'($urandom_range(1, 9999));
    if ($urandom_range(0, 1) != 0) return YEAR_W'($urandom_range(1, 4));
    return YEAR_W'($urandom_range(9996, 9999));
  endfunction

  // Random operation: every field carries noise, the one that matters is shaped.
  function automatic in_t random_op();
    in_t op;
    int  pick;
    int  sel;
    pick = $urandom_range(0, 99);
    sel = $urandom_range(0, 9);
    op.day        = DAY_W'($urandom);
    op.month      = MONTH_W'($urandom);
    op.year       = YEAR_W'($urandom);
    op.day_offset = OFFSET_W'($urandom);
    op.epoch_days = EPOCH_W'($urandom);
    if (pick < 25) begin
      op.mode = MODE_LOAD;
      if (sel < 7) begin
        op.year  = pick_year();
        op.month = MONTH_W'($urandom_range(1, 12));
        op.day   = DAY_W'($urandom_range(1, days_in(int'(op.month), int'(op.year))));
      end
    end else if (pick < 60) begin
      op.mode = MODE_ADD;
      if (sel < 7) op.day_offset = OFFSET_W'($urandom_range(0, 800) - 400);
      else if (sel < 9) op.day_offset = OFFSET_W'($urandom_range(0, 8000) - 4000);
    end else if (pick < 80) begin
      op.mode = MODE_COMPARE;
      if (sel < 8) begin
        op.day   = cal_day;
        op.month = cal_month;
        op.year  = cal_year;
      end
      // Nudge one field of the stored date by one either way.
      if (sel >= 5 && sel < 8) begin
        case ($urandom_range(0, 2))
          0:       op.day = $urandom_range(0, 1) ? cal_day + 5'd1 : cal_day - 5'd1;
          1:       op.month = $urandom_range(0, 1) ? cal_month + 4'd1 : cal_month - 4'd1;
          default: op.year = $urandom_range(0, 1) ? cal_year + 14'd1 : cal_year - 14'd1;
        endcase
      end
    end else begin
      op.mode = MODE_EPOCH;
      if (sel < 6) op.epoch_days = EPOCH_W'($urandom_range(0, 2932956));
      else if (sel < 8) op.epoch_days = EPOCH_W'($urandom_range(2932800, 2933100));
      else if (sel < 9) op.epoch_days = EPOCH_W'($urandom_range(0, 3000));
    end
    return op;
  endfunction

  // Input pacing: bursts of random length, each followed by a random gap.
  task automatic pace();
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? 48 : $urandom_range(1, 12);
    end
    burst_left = burst_left - 1;
  endtask

  // Offers one operation, waits for the transaction and records its result.
  task automatic offer_op(input in_t op, input logic typed, input res_t typed_res);
    res_t predicted;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {3'b000, op.epoch_days, op.day_offset, op.year, op.month, op.day};
    s_axis_tuser  <= op.mode;
    do @(posedge clk); while (!s_axis_tready);
    predicted = advance_calendar(op);
    expected_dates.push_back(typed ? typed_res : predicted);
  endtask

  // Stimulus
  initial begin
    rst           <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= '0;
    cal_day   = FIRST_DAY;
    cal_month = MONTH_JAN;
    cal_year  = RESET_YEAR;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < SCRIPT_LEN; i++) begin
      pace();
      offer_op(DATE_SCRIPT[i].op, DATE_SCRIPT[i].typed, DATE_SCRIPT[i].res);
    end
    for (int i = 0; i < RANDOM_OPS; i++) begin
      pace();
      offer_op(random_op(), 1'b0, NONE);
    end
    s_axis_tvalid <= 1'b0;

    while (expected_dates.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Receiver: stall styles that change after spans of random length, plus one long
  // hold-off that backs the core up into its input.
  initial begin
    int  style;
    int  span;
    bit  held_off;
    held_off = 1'b0;
    m_axis_tready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!held_off && results_seen >= HOLD_AFTER) begin
        held_off = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      style = $urandom_range(0, 3);
      span  = $urandom_range(16, 96);
      for (int i = 0; i < span; i++) begin
        case (style)
          0:       m_axis_tready <= 1'b1;
          1:       m_axis_tready <= 1'($urandom_range(0, 1));
          2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
          default: m_axis_tready <= i[2];
        endcase
        @(posedge clk);
      end
    end
  end

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  // Result checking against the oldest outstanding expectation.
  always @(posedge clk) begin : result_check
    res_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (expected_dates.size() == 0) begin
        $error("result transaction with no operation outstanding: tdata %h", m_axis_tdata);
        mismatch_count++;
      end else begin
        want = expected_dates.pop_front();
        check_field("out_day", want.day, m_axis_tdata[4:0]);
        check_field("out_month", want.month, m_axis_tdata[8:5]);
        check_field("out_year", want.year, m_axis_tdata[22:9]);
        check_field("valid_res", want.valid, m_axis_tdata[23]);
        check_field("order", want.order, m_axis_tdata[25:24]);
        check_field("out_of_range", want.oor, m_axis_tdata[26]);
      end
    end
  end

  // Watchdog, several times the slowest legal run.
  initial begin
    #60_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

[filelist.f]
+incdir+src
src/cda_pkg.sv
src/cda_alu.sv
src/cda_engine.sv
src/calendar_date_arithmetic_core.sv
tb/calendar_date_arithmetic_core_tb.sv
